// ===== hdl/gtp_pkg.sv =====
// Shared types and constants for the Goertzel tone power block.
package gtp_pkg;

  // Multiplier limb size: the shared unit multiplies one limb pair per cycle
  localparam int LIMB_W     = 32;
  localparam int LIMB_IDX_W = 2;

  // Fixed field and register widths
  localparam int COEF_W      = 16;
  localparam int WLOG_W      = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int POWER_W     = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_COEF   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW = 2'd1;

  // Register reset values
  localparam logic [COEF_W-1:0] COEF_RESET = 16'd32714;
  localparam logic [WLOG_W-1:0] WLOG_RESET = 4'd14;

  // Fixed-point scaling
  localparam int COEF_FRAC      = 14;  // c is Q2.14
  localparam int ROUND_BIAS_POS = 13;  // half of one LSB after the 14-bit shift
  localparam int PWR_SHIFT_BASE = 12;  // power shift is 2*window_log2 + 12

  // Per-cycle control of the shared multiply-accumulate unit
  typedef struct packed {
    logic                  acc_clr;    // load accumulator (zero or rounding bias)
    logic                  acc_round;  // with acc_clr: load the rounding bias
    logic                  mul_go;     // multiply the selected limb pair
    logic [LIMB_IDX_W-1:0] xi;         // limb of x operand
    logic [LIMB_IDX_W-1:0] yi;         // limb of y operand
    logic                  x_signed;   // x limb is the top (signed) limb
    logic                  y_signed;   // y limb is the top (signed) limb
    logic                  neg;        // subtract the partial product
    logic                  shl14;      // scale the partial product by 2^14
  } mac_ctrl_t;

endpackage

// ===== hdl/gtp_mac.sv =====
// Shared limb multiplier with shift-and-accumulate for the Goertzel datapath.
module gtp_mac #(
  parameter int X_WIDTH   = 64,
  parameter int Y_WIDTH   = 64,
  parameter int ACC_WIDTH = 112
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gtp_pkg::mac_ctrl_t    ctrl,
  input  logic [X_WIDTH-1:0]    op_x,
  input  logic [Y_WIDTH-1:0]    op_y,
  output logic [ACC_WIDTH-1:0]  acc
);

  localparam int LW     = gtp_pkg::LIMB_W;
  localparam int PROD_W = 2 * (LW + 1);
  localparam int SH_W   = 8;

  logic [X_WIDTH-1:0]       x_shifted;
  logic [Y_WIDTH-1:0]       y_shifted;
  logic [LW-1:0]            x_limb;
  logic [LW-1:0]            y_limb;
  logic signed [LW:0]       x_ext;
  logic signed [LW:0]       y_ext;
  logic signed [PROD_W-1:0] product;
  logic [SH_W-1:0]          sh;

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_valid;
  logic                     neg_q;
  logic [SH_W-1:0]          sh_q;

  logic [ACC_WIDTH-1:0]     prod_wide;
  logic [ACC_WIDTH-1:0]     term;

  // Limb select: lower limbs are unsigned, the top limb carries the sign
  always_comb begin
    x_shifted = op_x >> (ctrl.xi * LW);
    y_shifted = op_y >> (ctrl.yi * LW);
    x_limb    = x_shifted[LW-1:0];
    y_limb    = y_shifted[LW-1:0];
    x_ext     = {ctrl.x_signed & x_limb[LW-1], x_limb};
    y_ext     = {ctrl.y_signed & y_limb[LW-1], y_limb};
    product   = x_ext * y_ext;
    sh        = SH_W'((ctrl.xi + ctrl.yi) * LW)
              + (ctrl.shl14 ? SH_W'(gtp_pkg::COEF_FRAC) : SH_W'(0));
  end

  // Product register
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_go) begin
      prod_q <= product;
      neg_q  <= ctrl.neg;
      sh_q   <= sh;
    end
  end

  // Align partial product and accumulate modulo 2^ACC_WIDTH
  always_comb begin
    prod_wide = ACC_WIDTH'(prod_q);
    term      = prod_wide << sh_q;
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc <= ctrl.acc_round ? (ACC_WIDTH'(1) << gtp_pkg::ROUND_BIAS_POS) : '0;
    end else if (prod_valid) begin
      acc <= neg_q ? (acc - term) : (acc + term);
    end
  end

endmodule

// ===== hdl/goertzel_tone_power.sv =====
// Goertzel single-bin tone power detector: sequencer, delays and result stage.
//
// Samples arrive on the s_* stream (s_tdata holds audio_sample). Each beat
// runs s = x + c*s1 - s2 on one shared 33x33 limb multiplier, so s_tready
// drops while a sample is in work. A sample passes through the limb
// products of c*s1 (ST_MUL), the product and accumulate step (ST_DRAIN)
// and the delay update (ST_SETUP) before the next beat can be taken.
// After 2^window_log2 samples the block computes the window power with the
// same multiplier in four passes (c*s1, -(c*s1)*s2, s1^2, s2^2), each one
// running its limb products and then ST_DRAIN and ST_SETUP. It then emits
// one beat on m_*: m_tdata is tone_power, m_tuser is power_saturated.
// The result sits in an output register; if the receiver stalls, the next
// samples are still taken and only a second finished window waits for it.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once;
// write them only while the block is idle.
// Reset (rst, synchronous) clears both delays, the sample counter and the
// output valid, and restores c = 32714 and window_log2 = 14.
module goertzel_tone_power #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int MAX_WINDOW_LOG2 = 15,
  parameter int DELAY_WIDTH     = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Sample stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_WIDTH-1:0] audio_sample
  // Result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [gtp_pkg::POWER_W-1:0]          m_tdata,   // [31:0] tone_power
  output logic                                 m_tuser,   // [0] power_saturated
  // Configuration writes
  input  logic                                 cfg_we,
  input  logic [gtp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [gtp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int DW    = DELAY_WIDTH;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int MW    = MAX_WINDOW_LOG2;
  localparam int NY    = (DW + 31) / 32;
  localparam int NX    = (DW + gtp_pkg::COEF_W + 31) / 32;
  localparam int XW    = NX * gtp_pkg::LIMB_W;
  localparam int YW    = NY * gtp_pkg::LIMB_W;
  localparam int AW    = 2 * DW + 16;
  localparam int IW    = gtp_pkg::LIMB_IDX_W;
  localparam int PW    = gtp_pkg::POWER_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MUL     = 3'd1;
  localparam logic [2:0] ST_DRAIN   = 3'd2;
  localparam logic [2:0] ST_SETUP   = 3'd3;
  localparam logic [2:0] ST_PWR_FIN = 3'd4;

  // Power passes
  localparam logic [1:0] PASS_CA = 2'd0;
  localparam logic [1:0] PASS_PB = 2'd1;
  localparam logic [1:0] PASS_AA = 2'd2;
  localparam logic [1:0] PASS_BB = 2'd3;

  logic [2:0]                         state;
  logic                               in_power;
  logic [1:0]                         pass;
  logic signed [gtp_pkg::COEF_W-1:0]  coef;
  logic [gtp_pkg::WLOG_W-1:0]         wlog;
  logic signed [DW-1:0]               s1;
  logic signed [DW-1:0]               s2;
  logic [MW-1:0]                      cnt;
  logic signed [SW-1:0]               sample;

  logic [XW-1:0]                      op_x;
  logic [YW-1:0]                      op_y;
  logic [IW-1:0]                      x_top;
  logic [IW-1:0]                      xi;
  logic [IW-1:0]                      yi;
  logic                               neg;
  logic                               shl14;

  gtp_pkg::mac_ctrl_t                 ctrl;
  logic [AW-1:0]                      acc;

  logic                               in_beat;
  logic                               mul_last;
  logic                               out_load;

  logic [4:0]                         wl_c;
  logic [5:0]                         sh_pwr;
  logic [MW-1:0]                      last;

  logic signed [DW+1:0]               rnd;
  logic signed [DW+2:0]               s_sum;
  logic                               s_in_range;
  logic signed [DW-1:0]               s_sat;

  logic [AW-1:0]                      acc_shifted;
  logic                               pwr_over;
  logic [PW-1:0]                      power;
  logic                               power_flag;

  assign in_beat  = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign mul_last = (xi == x_top) && (yi == IW'(NY - 1));
  assign out_load = (state == ST_PWR_FIN) && (!m_tvalid || m_tready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= gtp_pkg::COEF_RESET;
      wlog <= gtp_pkg::WLOG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == gtp_pkg::REG_COEF) begin
        coef <= cfg_wdata;
      end else if (cfg_index == gtp_pkg::REG_WINDOW) begin
        wlog <= cfg_wdata[gtp_pkg::WLOG_W-1:0];
      end
    end
  end

  // Window length: clamp to 1..MAX_WINDOW_LOG2
  always_comb begin
    if (wlog == '0) begin
      wl_c = 5'd1;
    end else if ({1'b0, wlog} > 5'(MW)) begin
      wl_c = 5'(MW);
    end else begin
      wl_c = {1'b0, wlog};
    end
    sh_pwr = {wl_c, 1'b0} + 6'(gtp_pkg::PWR_SHIFT_BASE);
    last   = MW'(((MW+1)'(1) << wl_c) - (MW+1)'(1));
  end

  // Recurrence update: x + round(c*s1) - s2, saturated to the delay range
  always_comb begin
    rnd        = acc[DW+gtp_pkg::COEF_FRAC+1:gtp_pkg::COEF_FRAC];
    s_sum      = (DW+3)'(sample) + (DW+3)'(rnd) - (DW+3)'(s2);
    s_in_range = (&s_sum[DW+2:DW-1]) || !(|s_sum[DW+2:DW-1]);
    if (s_in_range) begin
      s_sat = s_sum[DW-1:0];
    end else if (s_sum[DW+2]) begin
      s_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      s_sat = {1'b0, {(DW-1){1'b1}}};
    end
  end

  // Window power: remove the 2^14 scale, scale by 4/N^2, clamp to 32 bits
  always_comb begin
    acc_shifted = acc >> sh_pwr;
    pwr_over    = |acc_shifted[AW-1:PW];
    if (acc[AW-1]) begin
      power      = '0;
      power_flag = 1'b0;
    end else if (pwr_over) begin
      power      = '1;
      power_flag = 1'b1;
    end else begin
      power      = acc_shifted[PW-1:0];
      power_flag = 1'b0;
    end
  end

  // Multiplier control for this cycle
  always_comb begin
    ctrl          = '0;
    ctrl.xi       = xi;
    ctrl.yi       = yi;
    ctrl.x_signed = (xi == x_top);
    ctrl.y_signed = (yi == IW'(NY - 1));
    ctrl.neg      = neg;
    ctrl.shl14    = shl14;
    ctrl.mul_go   = (state == ST_MUL);
    if (in_beat) begin
      ctrl.acc_clr   = 1'b1;
      ctrl.acc_round = 1'b1;
    end else if (state == ST_SETUP) begin
      if (!in_power) begin
        ctrl.acc_clr = !(cnt < last);
      end else begin
        ctrl.acc_clr = (pass == PASS_CA);
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_power <= 1'b0;
      pass     <= PASS_CA;
      s1       <= '0;
      s2       <= '0;
      cnt      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          if (!in_power) begin
            s2 <= s1;
            s1 <= s_sat;
            if (cnt < last) begin
              cnt   <= cnt + MW'(1);
              state <= ST_IDLE;
            end else begin
              in_power <= 1'b1;
              pass     <= PASS_CA;
              state    <= ST_MUL;
            end
          end else begin
            unique case (pass)
              PASS_CA: begin
                pass  <= PASS_PB;
                state <= ST_MUL;
              end
              PASS_PB: begin
                pass  <= PASS_AA;
                state <= ST_MUL;
              end
              PASS_AA: begin
                pass  <= PASS_BB;
                state <= ST_MUL;
              end
              PASS_BB: begin
                state <= ST_PWR_FIN;
              end
              default: begin
                state <= ST_PWR_FIN;
              end
            endcase
          end
        end
        ST_PWR_FIN: begin
          if (out_load) begin
            s1       <= '0;
            s2       <= '0;
            cnt      <= '0;
            in_power <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Operand registers and limb counters
  always_ff @(posedge clk) begin
    if (in_beat) begin
      sample <= s_tdata[SW-1:0];
      op_x   <= XW'(coef);
      op_y   <= YW'(s1);
      x_top  <= '0;
      neg    <= 1'b0;
      shl14  <= 1'b0;
      xi     <= '0;
      yi     <= '0;
    end else if (state == ST_MUL) begin
      if (xi == x_top) begin
        xi <= '0;
        yi <= yi + IW'(1);
      end else begin
        xi <= xi + IW'(1);
      end
    end else if (state == ST_SETUP) begin
      xi <= '0;
      yi <= '0;
      if (!in_power) begin
        // first power pass: c * s1, with s1 the value just formed
        op_x  <= XW'(coef);
        op_y  <= YW'(s_sat);
        x_top <= '0;
        neg   <= 1'b0;
        shl14 <= 1'b0;
      end else begin
        case (pass)
          PASS_CA: begin
            op_x  <= acc[XW-1:0];
            op_y  <= YW'(s2);
            x_top <= IW'(NX - 1);
            neg   <= 1'b1;
          end
          PASS_PB: begin
            op_x  <= XW'(s1);
            op_y  <= YW'(s1);
            x_top <= IW'(NY - 1);
            neg   <= 1'b0;
            shl14 <= 1'b1;
          end
          PASS_AA: begin
            op_x  <= XW'(s2);
            op_y  <= YW'(s2);
          end
          default: begin
            op_x  <= op_x;
          end
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= power;
      m_tuser <= power_flag;
    end
  end

  gtp_mac #(
    .X_WIDTH   (XW),
    .Y_WIDTH   (YW),
    .ACC_WIDTH (AW)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .op_x (op_x),
    .op_y (op_y),
    .acc  (acc)
  );

  // No sample is taken while the window power is in work
  a_no_beat_in_power: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !in_power)
    else $error("sample ready during power computation");

  // A saturated result always reads as full scale
  a_sat_full_scale: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '1))
    else $error("saturation flag without clamped power");

  // A new result comes only from the power stage, which restarts the window
  a_result_restarts: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_PWR_FIN) && (cnt == '0) && (s1 == '0))
    else $error("result without window restart");

endmodule
